// ----- sv/slfp_pkg.sv -----
// ----------------------------------------------------------------------------
// slfp_pkg: shared types and constants of the sync/length/XOR frame parser
// Field widths, status codes, command codes, register indexes and the job
// record that passes from the parser front end to the result back end.
// ----------------------------------------------------------------------------
package slfp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned PIDX_W      = 6;
  localparam int unsigned FLEN_W      = 7;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

  // Command codes
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE = 3'd0,
    ST_SYNC = 3'd1,
    ST_LEN  = 3'd2,
    ST_DATA = 3'd3,
    ST_CSUM = 3'd4,
    ST_DONE = 3'd5,
    ST_ERR  = 3'd6
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } back_state_e;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status_code;
    logic                payload_flag;
    logic [BYTE_W-1:0]   payload_byte;
    logic [PIDX_W-1:0]   payload_index;
    logic [FLEN_W-1:0]   frame_length;
    logic                last;
  } out_item_t;

  // One entry per accepted item: either a single status result or a readout
  typedef struct packed {
    logic              readout;
    status_e           status;
    logic [BYTE_W-1:0] frame_len;
  } job_t;

  // Payload store write port, front end to back end
  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

endpackage

// ----- sv/slfp_queue.sv -----
// ----------------------------------------------------------------------------
// slfp_queue: short job queue
// Small FIFO of job records between the parser front end and the back end.
// ----------------------------------------------------------------------------
module slfp_queue
  import slfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ----- sv/slfp_front.sv -----
// ----------------------------------------------------------------------------
// slfp_front: parser front end
// Holds the sync registers, runs the frame parser on each accepted byte,
// writes payload bytes to the store and queues one job per item.
// ----------------------------------------------------------------------------
module slfp_front
  import slfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 push_o,
  output job_t                 push_job_o,
  input  logic                 queue_full_i,
  input  logic                 readout_done_i,
  output store_wr_t            store_wr_o
);

  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);

  logic [BYTE_W-1:0] sync_first_q, sync_second_q;
  status_e           phase_q, phase_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] csum_q, csum_d;
  logic              busy_q;
  logic              accept;
  logic              readout;
  logic [BYTE_W-1:0] b;

  assign b          = in_data_i.data_byte;
  // Hold input while the job queue is full or a payload readout is queued or running
  assign in_ready_o = !queue_full_i && !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d         = phase_q;
    len_d           = len_q;
    count_d         = count_q;
    csum_d          = csum_q;
    readout         = 1'b0;
    store_wr_o.en   = 1'b0;
    store_wr_o.addr = BYTE_W'(count_q);
    store_wr_o.data = b;
    if (in_data_i.cmd == CMD_RESTART) begin
      phase_d = ST_IDLE;
      len_d   = '0;
      count_d = '0;
      csum_d  = '0;
    end else begin
      unique case (phase_q)
        ST_IDLE: begin
          if (b == sync_first_q) phase_d = ST_SYNC;
        end
        ST_SYNC: begin
          phase_d = (b == sync_second_q) ? ST_LEN : ST_ERR;
        end
        ST_LEN: begin
          count_d = '0;
          csum_d  = b;
          if (b != '0 && b <= BYTE_W'(MAX_PAYLOAD)) begin
            len_d   = LEN_W'(b);
            phase_d = ST_DATA;
          end else begin
            len_d   = '0;
            phase_d = ST_ERR;
          end
        end
        ST_DATA: begin
          store_wr_o.en = accept;
          count_d       = count_q + 1'b1;
          csum_d        = csum_q ^ b;
          if (count_d >= len_q) phase_d = ST_CSUM;
        end
        ST_CSUM: begin
          if (b == csum_q) begin
            phase_d = ST_DONE;
            readout = 1'b1;
          end else begin
            phase_d = ST_ERR;
          end
        end
        ST_DONE, ST_ERR: ;
        default: ;
      endcase
    end
    push_o               = accept;
    push_job_o.readout   = readout;
    push_job_o.status    = phase_d;
    push_job_o.frame_len = BYTE_W'(len_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      phase_q       <= ST_IDLE;
      len_q         <= '0;
      count_q       <= '0;
      csum_q        <= '0;
      busy_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i;
          CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept) begin
        phase_q <= phase_d;
        len_q   <= len_d;
        count_q <= count_d;
        csum_q  <= csum_d;
      end
      if (accept && readout) begin
        busy_q <= 1'b1;
      end else if (readout_done_i) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/slfp_back.sv -----
// ----------------------------------------------------------------------------
// slfp_back: result back end
// Owns the payload store and the output register; turns queued jobs into
// status results or a payload readout of one byte per cycle while the output can load.
// ----------------------------------------------------------------------------
module slfp_back
  import slfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  store_wr_t store_wr_i,
  input  job_t      head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      readout_done_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rdata_q;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  back_state_e       state_q, state_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic [LEN_W-1:0]  n_q, n_d;
  logic [FLEN_W-1:0] flen_q, flen_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              load_ok;
  logic              is_last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign load_ok     = !out_valid_q || out_ready_i;
  assign is_last     = (LEN_W'(idx_q + 1'b1) == n_q);

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    n_d            = n_q;
    flen_d         = flen_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_d          = out_q;
    pop_o          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = idx_q[AW-1:0];
    readout_done_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          if (head_i.readout) begin
            // Start readout: fetch first byte, emit it in the emit state once the output can load
            pop_o   = 1'b1;
            n_d     = LEN_W'(head_i.frame_len);
            flen_d  = FLEN_W'(head_i.frame_len);
            idx_d   = '0;
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = BK_EMIT;
          end else if (load_ok) begin
            pop_o               = 1'b1;
            out_valid_d         = 1'b1;
            out_d.status_code   = head_i.status;
            out_d.payload_flag  = 1'b0;
            out_d.payload_byte  = '0;
            out_d.payload_index = '0;
            out_d.frame_length  = FLEN_W'(head_i.frame_len);
            out_d.last          = 1'b1;
          end
        end
      end
      BK_EMIT: begin
        if (load_ok) begin
          out_valid_d         = 1'b1;
          out_d.status_code   = ST_DONE;
          out_d.payload_flag  = 1'b1;
          out_d.payload_byte  = rdata_q;
          out_d.payload_index = PIDX_W'(idx_q);
          out_d.frame_length  = flen_q;
          out_d.last          = is_last;
          if (is_last) begin
            readout_done_o = 1'b1;
            state_d        = BK_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_d[AW-1:0];
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    flen_q <= flen_d;
  end

  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) begin
      mem[store_wr_i.addr[AW-1:0]] <= store_wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/sync_length_xor_frame_parser.sv -----
// A status job is written to the job queue, then its result loads the output register.
// One byte per cycle while parsing and the job queue has room; a good checksum starts
// a payload readout of one byte per cycle while the output can load, after the first
// store read; input stalls from the checksum until the last payload result is loaded.
// Reset: asynchronous, active low; parser, queue and output go idle, sync
// registers take 0xAA/0x55, payload store contents stay undefined.
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser: length-prefixed frame parser, XOR checksum
// Recognises frames of two sync bytes, a length byte, payload and an XOR
// checksum. The front end parses and queues jobs; the back end emits results.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_parser
  import slfp_pkg::*;
#(
  // Payload store depth and the largest accepted length byte
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes: index 0 is the first sync byte, index 1 the second
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  // Received bytes and restart commands
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  // Results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  // Job queue between front and back end
  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      head;
  logic      q_empty;
  logic      q_full;
  // Front end is held off until the back end has issued the last payload result
  logic      readout_done;
  store_wr_t store_wr;

  slfp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .push_o        (push),
    .push_job_o    (push_job),
    .queue_full_i  (q_full),
    .readout_done_i(readout_done),
    .store_wr_o    (store_wr)
  );

  // Each transfer yields exactly one job, so ordering of results follows input
  slfp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  // Back end owns the payload store; writes come from the front end
  slfp_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .store_wr_i    (store_wr),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .readout_done_o(readout_done),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ----- sim/sync_length_xor_frame_parser_tb.sv -----
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser_tb: self-checking bench for the frame parser
// Drives received bytes and restart commands through the valid/ready input,
// mirrors the parser in a behavioural predictor and checks every result
// transfer, field by field, against the oldest predicted result. Covers the
// error and completion paths, sync byte settings, output hold-off and
// randomised traffic with random idling on both sides.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_parser_tb;
  import slfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_QUOTA = 6;    // counted transfers per random phase, noise excluded
  localparam int unsigned HOLD_CYCLES  = 400;  // output hold-off for the pressure test
  localparam int unsigned PRESS_LEN    = 24;   // payload length offered under hold-off

  // Frame shapes used by the frame builder
  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SYNC,
    FRAME_BAD_CSUM,
    FRAME_CUT
  } frame_kind_e;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BYTE_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_data_o;

  // --------------------------------------------------------------------------
  // Predictor state: a behavioural copy of the parser and its sync registers
  // --------------------------------------------------------------------------
  status_e           parser_phase  = ST_IDLE;
  logic [FLEN_W-1:0] frame_len_q   = '0;
  logic [FLEN_W-1:0] rx_count      = '0;
  logic [BYTE_W-1:0] xor_acc       = '0;
  logic [BYTE_W-1:0] sync_first_q  = SYNC_FIRST_RST;
  logic [BYTE_W-1:0] sync_second_q = SYNC_SECOND_RST;
  logic [BYTE_W-1:0] payload_copy [MAX_PAYLOAD_DEF];

  out_item_t   expected_results [$];

  // Bookkeeping
  int unsigned transfers_total = 0;
  int unsigned results_seen    = 0;
  int unsigned mismatches      = 0;
  int unsigned sync_settings   = 1;
  int unsigned cycles          = 0;
  int          hold_left       = 0;  // receiver hold-off, counted down by the receiver
  bit          no_idle         = 1'b0;

  sync_length_xor_frame_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hang anywhere (lost result, stuck ready) ends the run here
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still awaited",
             cycles, expected_results.size());
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor: updates the model state for one accepted transfer and queues
  // the results it causes. A checksum match queues the whole payload readout
  // instead of a status result.
  // --------------------------------------------------------------------------
  function automatic void predict_transfer(input in_item_t item);
    out_item_t res;
    res = '0;
    if (item.cmd == CMD_RESTART) begin
      parser_phase = ST_IDLE;
      frame_len_q  = '0;
      rx_count     = '0;
      xor_acc      = '0;
    end else begin
      case (parser_phase)
        ST_IDLE: if (item.data_byte == sync_first_q) parser_phase = ST_SYNC;
        ST_SYNC: parser_phase = (item.data_byte == sync_second_q) ? ST_LEN : ST_ERR;
        ST_LEN: begin
          rx_count = '0;
          xor_acc  = item.data_byte;
          if (item.data_byte >= 1 && item.data_byte <= MAX_PAYLOAD_DEF) begin
            frame_len_q  = FLEN_W'(item.data_byte);
            parser_phase = ST_DATA;
          end else begin
            // no valid length seen, so the reported length drops to zero
            frame_len_q  = '0;
            parser_phase = ST_ERR;
          end
        end
        ST_DATA: begin
          payload_copy[rx_count[PIDX_W-1:0]] = item.data_byte;
          rx_count++;
          xor_acc ^= item.data_byte;
          if (rx_count >= frame_len_q) parser_phase = ST_CSUM;
        end
        ST_CSUM: begin
          if (item.data_byte == xor_acc) begin
            parser_phase = ST_DONE;
            for (int i = 0; i < frame_len_q; i++) begin
              res.status_code   = ST_DONE;
              res.payload_flag  = 1'b1;
              res.payload_byte  = payload_copy[i];
              res.payload_index = PIDX_W'(i);
              res.frame_length  = frame_len_q;
              res.last          = (i == frame_len_q - 1);
              expected_results.push_back(res);
            end
            return;
          end
          parser_phase = ST_ERR;
        end
        default: ;  // complete and error are sticky: bytes ignored
      endcase
    end
    res.status_code  = parser_phase;
    res.frame_length = frame_len_q;
    res.last         = 1'b1;
    expected_results.push_back(res);
  endfunction

  // --------------------------------------------------------------------------
  // Result checker. Output valid and ready are stable by the falling edge, so
  // a transfer seen here is the one that completes at the next rising edge.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected result: st=%0d flag=%0d byte=%h idx=%0d len=%0d last=%0d",
                   $time, out_data_o.status_code, out_data_o.payload_flag,
                   out_data_o.payload_byte, out_data_o.payload_index,
                   out_data_o.frame_length, out_data_o.last);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status_code   !== want.status_code   ||
            out_data_o.payload_flag  !== want.payload_flag  ||
            out_data_o.payload_byte  !== want.payload_byte  ||
            out_data_o.payload_index !== want.payload_index ||
            out_data_o.frame_length  !== want.frame_length  ||
            out_data_o.last          !== want.last) begin
          if (mismatches < 10) begin
            $display("[%0t] mismatch on result %0d", $time, results_seen);
            $display("  expected st=%0d flag=%0d byte=%h idx=%0d len=%0d last=%0d",
                     want.status_code, want.payload_flag, want.payload_byte,
                     want.payload_index, want.frame_length, want.last);
            $display("  actual   st=%0d flag=%0d byte=%h idx=%0d len=%0d last=%0d",
                     out_data_o.status_code, out_data_o.payload_flag,
                     out_data_o.payload_byte, out_data_o.payload_index,
                     out_data_o.frame_length, out_data_o.last);
          end
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, a requested hold-off, or always ready
  // --------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 14);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge where the transfer
  // happened, with valid still high so back-to-back items need no bubble.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t item);
    if (!no_idle && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    predict_transfer(item);
    transfers_total++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    in_item_t item;
    item.cmd       = CMD_DATA;
    item.data_byte = value;
    send_item(item);
  endtask

  // Restart carries a random, ignored data byte
  task automatic send_restart();
    in_item_t item;
    item.cmd       = CMD_RESTART;
    item.data_byte = 8'($urandom);
    send_item(item);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both sync registers; only called with the parser drained
  task automatic set_sync_bytes(input logic [BYTE_W-1:0] first,
                                input logic [BYTE_W-1:0] second);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SYNC_FIRST;
    cfg_wdata_i <= first;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SYNC_SECOND;
    cfg_wdata_i <= second;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sync_first_q  = first;
    sync_second_q = second;
    sync_settings++;
  endtask

  // Builds one frame from the current sync bytes. An out-of-range length
  // stops after the length byte; a cut frame stops partway into the payload.
  task automatic send_frame(input int unsigned len, input frame_kind_e kind);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] value;
    int unsigned       count;
    int unsigned       pick;
    send_byte(sync_first_q);
    if (kind == FRAME_BAD_SYNC) begin
      send_byte(sync_second_q ^ 8'($urandom_range(255, 1)));
      return;
    end
    send_byte(sync_second_q);
    send_byte(8'(len));
    if (len < 1 || len > MAX_PAYLOAD_DEF) return;
    count = (kind == FRAME_CUT) ? $urandom_range(len - 1, 0) : len;
    sum   = 8'(len);
    for (int n = 0; n < count; n++) begin
      pick  = $urandom_range(99);
      value = (pick < 10) ? 8'h00 : (pick < 20) ? 8'hFF : 8'($urandom);
      sum  ^= value;
      send_byte(value);
    end
    if (kind == FRAME_CUT) return;
    send_byte((kind == FRAME_BAD_CSUM) ? sum ^ 8'($urandom_range(255, 1)) : sum);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Restart while idle, then bytes in idle that are not the first sync byte
  task automatic test_idle_bytes();
    send_restart();
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_idle();
  endtask

  // Wrong second sync byte goes to error; a byte in error stays there
  task automatic test_bad_sync();
    send_byte(8'hAA);
    send_byte(8'h00);
    send_byte(8'hAA);
    send_restart();
    wait_idle();
  endtask

  // Length of zero and one past the maximum both go to error
  task automatic test_bad_length();
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h00);
    send_restart();
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'(MAX_PAYLOAD_DEF + 1));
    send_restart();
    wait_idle();
  endtask

  // Checksum mismatch, then a good one-byte frame and a byte in complete
  task automatic test_checksum();
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'hFF);  // correct would be 0xFE
    send_restart();
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h01);
    send_byte(8'h5A);
    send_byte(8'h5B);
    send_byte(8'h00);  // ignored, phase stays complete
    send_restart();
    wait_idle();
  endtask

  // Sync registers at their extremes, both ways round
  task automatic test_sync_extremes();
    set_sync_bytes(8'h00, 8'hFF);
    send_frame(1, FRAME_GOOD);
    send_restart();
    wait_idle();
    set_sync_bytes(8'hFF, 8'h00);
    send_frame(2, FRAME_GOOD);
    send_restart();
    wait_idle();
  endtask

  // Receiver holds off while a long frame and another behind it are
  // offered without gaps: the results back up and the input must stall
  task automatic test_backpressure();
    no_idle   = 1'b1;
    hold_left = HOLD_CYCLES;
    send_frame(PRESS_LEN, FRAME_GOOD);
    send_restart();
    send_frame(3, FRAME_GOOD);
    send_restart();
    wait_idle();
    no_idle = 1'b0;
  endtask

  // Mostly well-formed frames with random content, mixed with broken frames,
  // cut frames and idle noise. Three sync settings; the middle one uses the
  // same value for both bytes and runs without any idling.
  task automatic test_random_traffic();
    int unsigned       start;
    int unsigned       ignored;
    int unsigned       mark;
    int unsigned       pick;
    int unsigned       len;
    logic [BYTE_W-1:0] noise;
    logic [BYTE_W-1:0] value;
    for (int phase = 0; phase < 3; phase++) begin
      value = 8'($urandom);
      if (phase == 1) set_sync_bytes(value, value);
      else            set_sync_bytes(value, 8'($urandom));
      no_idle = (phase == 1);
      start   = transfers_total;
      ignored = 0;
      while (transfers_total - start - ignored < RANDOM_QUOTA) begin
        pick = $urandom_range(99);
        len  = $urandom_range(8, 1);
        if (pick < 10) begin
          // idle noise never matches the first sync byte
          mark = transfers_total;
          repeat ($urandom_range(3, 1)) begin
            do noise = 8'($urandom); while (noise == sync_first_q);
            send_byte(noise);
          end
          ignored += transfers_total - mark;
        end else begin
          if      (pick < 72) send_frame(len, FRAME_GOOD);
          else if (pick < 80) send_frame(len, FRAME_BAD_CSUM);
          else if (pick < 86) send_frame(len, FRAME_BAD_SYNC);
          else if (pick < 92)
            send_frame(($urandom_range(1) == 0) ? 0 : $urandom_range(255, MAX_PAYLOAD_DEF + 1),
                       FRAME_GOOD);
          else                send_frame(len, FRAME_CUT);
          // occasional byte while parked in complete or error
          if (pick < 92 && $urandom_range(99) < 25) begin
            send_byte(8'($urandom));
            ignored++;
          end
          send_restart();
        end
      end
      wait_idle();
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_SYNC_FIRST;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_bytes();
    test_bad_sync();
    test_bad_length();
    test_checksum();
    test_sync_extremes();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d input transfers and %0d result transfers in %0d cycles,",
             transfers_total, results_seen, cycles);
    $display("over %0d sync byte settings with a %0d-cycle output hold-off; %0d mismatches.",
             sync_settings, HOLD_CYCLES, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
